// File: hdl/xcr_pkg.sv
// ----------------------------------------------------------------------------
// xcr_pkg
// Shared constants and types for the XMODEM checksum receiver.
// ----------------------------------------------------------------------------
package xcr_pkg;

    localparam int BLOCK_BYTES         = 128;
    localparam int IDX_W               = $clog2(BLOCK_BYTES);
    localparam int OFFSET_BITS_DEFAULT = 20;
    localparam int OFFSET_W            = 20;
    localparam int SIZE_W              = 21;
    localparam int INTERVAL_W          = 16;

    localparam logic [INTERVAL_W-1:0] NAK_INTERVAL_RESET = 16'd2000;

    // protocol control bytes and the block-number complement mask
    localparam logic [7:0] BYTE_SOH = 8'h01;
    localparam logic [7:0] BYTE_EOT = 8'h04;
    localparam logic [7:0] BYTE_CAN = 8'h18;
    localparam logic [7:0] BYTE_ONES = 8'hff;

    // op codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // reply codes
    localparam logic [1:0] RPL_NONE = 2'd0;
    localparam logic [1:0] RPL_ACK  = 2'd1;
    localparam logic [1:0] RPL_NAK  = 2'd2;

    // status codes
    localparam logic [1:0] ST_BUSY   = 2'd0;
    localparam logic [1:0] ST_DONE   = 2'd1;
    localparam logic [1:0] ST_CANCEL = 2'd2;
    localparam logic [1:0] ST_ERROR  = 2'd3;

    typedef struct packed {
        logic                op;
        logic [7:0]          rx_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]          reply;
        logic                data_valid;
        logic [OFFSET_W-1:0] data_offset;
        logic [7:0]          data_byte;
        logic [1:0]          status;
        logic [SIZE_W-1:0]   total_size;
    } result_t;

endpackage

// File: hdl/xcr_in_stage.sv
// ----------------------------------------------------------------------------
// xcr_in_stage
// Input register: holds one word until the core takes it.
// ----------------------------------------------------------------------------
module xcr_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  xcr_pkg::item_t  in_item,
    input  logic            take,
    output logic            item_valid,
    output xcr_pkg::item_t  item
);

    logic           valid_reg;
    logic           valid_next;
    xcr_pkg::item_t item_reg;
    logic           load;

    assign in_stall   = valid_reg && !take;
    assign load       = in_valid && !in_stall;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: hdl/xcr_core.sv
// ----------------------------------------------------------------------------
// xcr_core
// Protocol state and per-word update logic of the receiver.
// ----------------------------------------------------------------------------
module xcr_core
#(
    parameter int OFFSET_BITS = xcr_pkg::OFFSET_BITS_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [xcr_pkg::INTERVAL_W-1:0]    cfg_data,
    input  logic                              fire,
    input  xcr_pkg::item_t                    item,
    output xcr_pkg::result_t                  result
);

    typedef enum logic [2:0] {
        PH_HDR    = 3'd0,
        PH_NUM    = 3'd1,
        PH_COMP   = 3'd2,
        PH_DATA   = 3'd3,
        PH_CSUM   = 3'd4,
        PH_DONE   = 3'd5,
        PH_CANCEL = 3'd6,
        PH_ERROR  = 3'd7
    } phase_t;

    localparam int CAP_BITS = (OFFSET_BITS < xcr_pkg::OFFSET_W) ? OFFSET_BITS
                                                                : xcr_pkg::OFFSET_W;
    localparam logic [xcr_pkg::SIZE_W:0] CAPACITY = (xcr_pkg::SIZE_W+1)'(1) << CAP_BITS;
    localparam logic [xcr_pkg::IDX_W-1:0] LAST_IDX = xcr_pkg::IDX_W'(xcr_pkg::BLOCK_BYTES - 1);

    phase_t                              phase_reg, phase_next;
    logic                                started_reg, started_next;
    logic [xcr_pkg::INTERVAL_W-1:0]      tick_count_reg, tick_count_next;
    logic [xcr_pkg::INTERVAL_W-1:0]      tick_inc;
    logic [xcr_pkg::INTERVAL_W-1:0]      nak_interval_reg;
    logic [7:0]                          expected_block_reg, expected_block_next;
    logic [7:0]                          received_block_reg, received_block_next;
    logic                                block_bad_reg, block_bad_next;
    logic                                csum_bad;
    logic [xcr_pkg::IDX_W-1:0]           byte_index_reg, byte_index_next;
    logic [7:0]                          running_sum_reg, running_sum_next;
    logic [xcr_pkg::SIZE_W-1:0]          image_size_reg, image_size_next;
    logic [xcr_pkg::SIZE_W:0]            size_after;
    logic [xcr_pkg::SIZE_W-1:0]          offset_sum;
    logic [1:0]                          reply;
    logic                                dvalid;
    logic [xcr_pkg::OFFSET_W-1:0]        doff;
    logic [7:0]                          dbyte;
    logic [1:0]                          status;

    assign tick_inc   = tick_count_reg + 1'b1;
    assign size_after = {1'b0, image_size_reg} + (xcr_pkg::SIZE_W+1)'(xcr_pkg::BLOCK_BYTES);
    assign offset_sum = image_size_reg + xcr_pkg::SIZE_W'(byte_index_reg);
    assign csum_bad   = block_bad_reg || (running_sum_reg != item.rx_byte);

    always_comb
    begin
        phase_next          = phase_reg;
        started_next        = started_reg;
        tick_count_next     = tick_count_reg;
        expected_block_next = expected_block_reg;
        received_block_next = received_block_reg;
        block_bad_next      = block_bad_reg;
        byte_index_next     = byte_index_reg;
        running_sum_next    = running_sum_reg;
        image_size_next     = image_size_reg;
        reply               = xcr_pkg::RPL_NONE;
        dvalid              = 1'b0;
        doff                = '0;
        dbyte               = '0;

        if (item.op == xcr_pkg::OP_TICK)
        begin
            if (phase_reg == PH_HDR && !started_reg)
            begin
                tick_count_next = tick_inc;
                if (tick_inc >= nak_interval_reg)
                begin
                    tick_count_next = '0;
                    reply           = xcr_pkg::RPL_NAK;
                end
            end
        end
        else
        begin
            case (phase_reg)
                PH_HDR:
                begin
                    tick_count_next = '0;
                    if (item.rx_byte == xcr_pkg::BYTE_EOT)
                    begin
                        reply      = xcr_pkg::RPL_ACK;
                        phase_next = PH_DONE;
                    end
                    else if (item.rx_byte == xcr_pkg::BYTE_CAN)
                    begin
                        phase_next = PH_CANCEL;
                    end
                    else if (item.rx_byte == xcr_pkg::BYTE_SOH)
                    begin
                        started_next = 1'b1;
                        if (size_after > CAPACITY)
                        begin
                            phase_next = PH_ERROR;
                        end
                        else
                        begin
                            block_bad_next   = 1'b0;
                            byte_index_next  = '0;
                            running_sum_next = '0;
                            phase_next       = PH_NUM;
                        end
                    end
                    else if (started_reg)
                    begin
                        phase_next = PH_ERROR;
                    end
                end
                PH_NUM:
                begin
                    received_block_next = item.rx_byte;
                    if (item.rx_byte != expected_block_reg)
                    begin
                        block_bad_next = 1'b1;
                    end
                    phase_next = PH_COMP;
                end
                PH_COMP:
                begin
                    if ((received_block_reg ^ item.rx_byte) != xcr_pkg::BYTE_ONES)
                    begin
                        block_bad_next = 1'b1;
                    end
                    phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    dvalid           = 1'b1;
                    doff             = offset_sum[xcr_pkg::OFFSET_W-1:0];
                    dbyte            = item.rx_byte;
                    running_sum_next = running_sum_reg + item.rx_byte;
                    if (byte_index_reg == LAST_IDX)
                    begin
                        byte_index_next = '0;
                        phase_next      = PH_CSUM;
                    end
                    else
                    begin
                        byte_index_next = byte_index_reg + 1'b1;
                    end
                end
                PH_CSUM:
                begin
                    if (csum_bad)
                    begin
                        reply = xcr_pkg::RPL_NAK;
                    end
                    else
                    begin
                        reply               = xcr_pkg::RPL_ACK;
                        expected_block_next = expected_block_reg + 1'b1;
                        image_size_next     = size_after[xcr_pkg::SIZE_W-1:0];
                    end
                    block_bad_next = 1'b0;
                    phase_next     = PH_HDR;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (phase_next)
            PH_DONE:   status = xcr_pkg::ST_DONE;
            PH_CANCEL: status = xcr_pkg::ST_CANCEL;
            PH_ERROR:  status = xcr_pkg::ST_ERROR;
            default:   status = xcr_pkg::ST_BUSY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nak_interval_reg   <= xcr_pkg::NAK_INTERVAL_RESET;
            phase_reg          <= PH_HDR;
            started_reg        <= 1'b0;
            tick_count_reg     <= '0;
            expected_block_reg <= 8'd1;
            received_block_reg <= '0;
            block_bad_reg      <= 1'b0;
            byte_index_reg     <= '0;
            running_sum_reg    <= '0;
            image_size_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                nak_interval_reg <= cfg_data;
            end
            if (fire)
            begin
                phase_reg          <= phase_next;
                started_reg        <= started_next;
                tick_count_reg     <= tick_count_next;
                expected_block_reg <= expected_block_next;
                received_block_reg <= received_block_next;
                block_bad_reg      <= block_bad_next;
                byte_index_reg     <= byte_index_next;
                running_sum_reg    <= running_sum_next;
                image_size_reg     <= image_size_next;
            end
        end
    end

    assign result.reply       = reply;
    assign result.data_valid  = dvalid;
    assign result.data_offset = doff;
    assign result.data_byte   = dbyte;
    assign result.status      = status;
    assign result.total_size  = image_size_next;

endmodule

// File: hdl/xcr_out_stage.sv
// ----------------------------------------------------------------------------
// xcr_out_stage
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module xcr_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  xcr_pkg::result_t  result,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_stall,
    output xcr_pkg::result_t  out_result
);

    logic              valid_reg;
    logic              valid_next;
    xcr_pkg::result_t  result_reg;

    assign ready      = !valid_reg || !out_stall;
    assign valid_next = fire ? 1'b1 : (ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// File: hdl/xmodem_checksum_receiver.sv
// ----------------------------------------------------------------------------
// xmodem_checksum_receiver
// XMODEM receiver for 128-byte blocks with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
// Each input word is a received byte or one tick of waiting time and gives
// exactly one result word. A word passes from the input register through the
// protocol update logic into the result register, and one word per cycle is
// sustained while out_stall is low; the only limit on throughput is out_stall.
// Before the first SOH a NAK is sent every nak_interval ticks. Data bytes come
// out with their image offset, a good block is ACKed, a bad one NAKed, EOT ends
// and CAN cancels the transfer, and the final status holds until reset. Write
// nak_interval only while idle.
module xmodem_checksum_receiver
#(
    parameter int OFFSET_BITS = xcr_pkg::OFFSET_BITS_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [xcr_pkg::INTERVAL_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              op,
    input  logic [7:0]                        rx_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        reply,
    output logic                              data_valid,
    output logic [xcr_pkg::OFFSET_W-1:0]      data_offset,
    output logic [7:0]                        data_byte,
    output logic [1:0]                        status,
    output logic [xcr_pkg::SIZE_W-1:0]        total_size
);

    xcr_pkg::item_t    in_item;
    xcr_pkg::item_t    item;
    logic              item_valid;
    logic              out_ready;
    logic              fire;
    xcr_pkg::result_t  result;
    xcr_pkg::result_t  out_result;

    assign cfg_ready       = 1'b1;
    assign in_item.op      = op;
    assign in_item.rx_byte = rx_byte;
    assign fire            = item_valid && out_ready;

    xcr_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .take       (out_ready),
        .item_valid (item_valid),
        .item       (item)
    );

    xcr_core
    #(
        .OFFSET_BITS (OFFSET_BITS)
    )
    u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .fire     (fire),
        .item     (item),
        .result   (result)
    );

    xcr_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .result     (result),
        .ready      (out_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign reply       = out_result.reply;
    assign data_valid  = out_result.data_valid;
    assign data_offset = out_result.data_offset;
    assign data_byte   = out_result.data_byte;
    assign status      = out_result.status;
    assign total_size  = out_result.total_size;

endmodule

// File: hdl/xcr_checker.sv
// ----------------------------------------------------------------------------
// xcr_checker
// Port-level checks of the XMODEM checksum receiver, bound to the top level.
// ----------------------------------------------------------------------------
module xcr_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [1:0]                        reply,
    input  logic                              data_valid,
    input  logic [xcr_pkg::OFFSET_W-1:0]      data_offset,
    input  logic [7:0]                        data_byte,
    input  logic [1:0]                        status,
    input  logic [xcr_pkg::SIZE_W-1:0]        total_size
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(reply) && $stable(status)
            && $stable(data_offset) && $stable(data_byte) && $stable(total_size))
        else $error("stalled result word changed");

    // a final status never goes away
    a_final_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != xcr_pkg::ST_BUSY |=> !out_valid || status == $past(status))
        else $error("final status changed");

    // payload words carry no reply and only while busy
    a_data_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data_valid |-> reply == xcr_pkg::RPL_NONE && status == xcr_pkg::ST_BUSY)
        else $error("payload word with reply or final status");

    // size grows in whole blocks only
    a_size_grows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |=> !out_valid
            || (total_size >= $past(total_size) && total_size[xcr_pkg::IDX_W-1:0] == '0))
        else $error("total size shrank or is not a whole number of blocks");

endmodule

bind xmodem_checksum_receiver xcr_checker u_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .reply       (reply),
    .data_valid  (data_valid),
    .data_offset (data_offset),
    .data_byte   (data_byte),
    .status      (status),
    .total_size  (total_size)
);
